// ===== hw/rtl/dcnp_pkg.sv =====
package dcnp_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef logic [31:0] sbox_row_t [64];

  localparam logic [5:0] PC1_TAB [56] = '{
    6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18,
    6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35, 6'd27, 6'd19, 6'd11, 6'd3,  6'd60, 6'd52, 6'd44, 6'd36,
    6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15, 6'd7,  6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22,
    6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21, 6'd13, 6'd5,  6'd28, 6'd20, 6'd12, 6'd4
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28
  };

  localparam logic [5:0] PC2_TAB [48] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  localparam logic [31:0] SBOX_P [8][64] = '{
  '{32'h00808200,32'h00000000,32'h00008000,32'h00808202,32'h00808002,32'h00008202,32'h00000002,32'h00008000,
    32'h00000200,32'h00808200,32'h00808202,32'h00000200,32'h00800202,32'h00808002,32'h00800000,32'h00000002,
    32'h00000202,32'h00800200,32'h00800200,32'h00008200,32'h00008200,32'h00808000,32'h00808000,32'h00800202,
    32'h00008002,32'h00800002,32'h00800002,32'h00008002,32'h00000000,32'h00000202,32'h00008202,32'h00800000,
    32'h00008000,32'h00808202,32'h00000002,32'h00808000,32'h00808200,32'h00800000,32'h00800000,32'h00000200,
    32'h00808002,32'h00008000,32'h00008200,32'h00800002,32'h00000200,32'h00000002,32'h00800202,32'h00008202,
    32'h00808202,32'h00008002,32'h00808000,32'h00800202,32'h00800002,32'h00000202,32'h00008202,32'h00808200,
    32'h00000202,32'h00800200,32'h00800200,32'h00000000,32'h00008002,32'h00008200,32'h00000000,32'h00808002},
  '{32'h40084010,32'h40004000,32'h00004000,32'h00084010,32'h00080000,32'h00000010,32'h40080010,32'h40004010,
    32'h40000010,32'h40084010,32'h40084000,32'h40000000,32'h40004000,32'h00080000,32'h00000010,32'h40080010,
    32'h00084000,32'h00080010,32'h40004010,32'h00000000,32'h40000000,32'h00004000,32'h00084010,32'h40080000,
    32'h00080010,32'h40000010,32'h00000000,32'h00084000,32'h00004010,32'h40084000,32'h40080000,32'h00004010,
    32'h00000000,32'h00084010,32'h40080010,32'h00080000,32'h40004010,32'h40080000,32'h40084000,32'h00004000,
    32'h40080000,32'h40004000,32'h00000010,32'h40084010,32'h00084010,32'h00000010,32'h00004000,32'h40000000,
    32'h00004010,32'h40084000,32'h00080000,32'h40000010,32'h00080010,32'h40004010,32'h40000010,32'h00080010,
    32'h00084000,32'h00000000,32'h40004000,32'h00004010,32'h40000000,32'h40080010,32'h40084010,32'h00084000},
  '{32'h00000104,32'h04010100,32'h00000000,32'h04010004,32'h04000100,32'h00000000,32'h00010104,32'h04000100,
    32'h00010004,32'h04000004,32'h04000004,32'h00010000,32'h04010104,32'h00010004,32'h04010000,32'h00000104,
    32'h04000000,32'h00000004,32'h04010100,32'h00000100,32'h00010100,32'h04010000,32'h04010004,32'h00010104,
    32'h04000104,32'h00010100,32'h00010000,32'h04000104,32'h00000004,32'h04010104,32'h00000100,32'h04000000,
    32'h04010100,32'h04000000,32'h00010004,32'h00000104,32'h00010000,32'h04010100,32'h04000100,32'h00000000,
    32'h00000100,32'h00010004,32'h04010104,32'h04000100,32'h04000004,32'h00000100,32'h00000000,32'h04010004,
    32'h04000104,32'h00010000,32'h04000000,32'h04010104,32'h00000004,32'h00010104,32'h00010100,32'h04000004,
    32'h04010000,32'h04000104,32'h00000104,32'h04010000,32'h00010104,32'h00000004,32'h04010004,32'h00010100},
  '{32'h80401000,32'h80001040,32'h80001040,32'h00000040,32'h00401040,32'h80400040,32'h80400000,32'h80001000,
    32'h00000000,32'h00401000,32'h00401000,32'h80401040,32'h80000040,32'h00000000,32'h00400040,32'h80400000,
    32'h80000000,32'h00001000,32'h00400000,32'h80401000,32'h00000040,32'h00400000,32'h80001000,32'h00001040,
    32'h80400040,32'h80000000,32'h00001040,32'h00400040,32'h00001000,32'h00401040,32'h80401040,32'h80000040,
    32'h00400040,32'h80400000,32'h00401000,32'h80401040,32'h80000040,32'h00000000,32'h00000000,32'h00401000,
    32'h00001040,32'h00400040,32'h80400040,32'h80000000,32'h80401000,32'h80001040,32'h80001040,32'h00000040,
    32'h80401040,32'h80000040,32'h80000000,32'h00001000,32'h80400000,32'h80001000,32'h00401040,32'h80400040,
    32'h80001000,32'h00001040,32'h00400000,32'h80401000,32'h00000040,32'h00400000,32'h00001000,32'h00401040},
  '{32'h00000080,32'h01040080,32'h01040000,32'h21000080,32'h00040000,32'h00000080,32'h20000000,32'h01040000,
    32'h20040080,32'h00040000,32'h01000080,32'h20040080,32'h21000080,32'h21040000,32'h00040080,32'h20000000,
    32'h01000000,32'h20040000,32'h20040000,32'h00000000,32'h20000080,32'h21040080,32'h21040080,32'h01000080,
    32'h21040000,32'h20000080,32'h00000000,32'h21000000,32'h01040080,32'h01000000,32'h21000000,32'h00040080,
    32'h00040000,32'h21000080,32'h00000080,32'h01000000,32'h20000000,32'h01040000,32'h21000080,32'h20040080,
    32'h01000080,32'h20000000,32'h21040000,32'h01040080,32'h20040080,32'h00000080,32'h01000000,32'h21040000,
    32'h21040080,32'h00040080,32'h21000000,32'h21040080,32'h01040000,32'h00000000,32'h20040000,32'h21000000,
    32'h00040080,32'h01000080,32'h20000080,32'h00040000,32'h00000000,32'h20040000,32'h01040080,32'h20000080},
  '{32'h10000008,32'h10200000,32'h00002000,32'h10202008,32'h10200000,32'h00000008,32'h10202008,32'h00200000,
    32'h10002000,32'h00202008,32'h00200000,32'h10000008,32'h00200008,32'h10002000,32'h10000000,32'h00002008,
    32'h00000000,32'h00200008,32'h10002008,32'h00002000,32'h00202000,32'h10002008,32'h00000008,32'h10200008,
    32'h10200008,32'h00000000,32'h00202008,32'h10202000,32'h00002008,32'h00202000,32'h10202000,32'h10000000,
    32'h10002000,32'h00000008,32'h10200008,32'h00202000,32'h10202008,32'h00200000,32'h00002008,32'h10000008,
    32'h00200000,32'h10002000,32'h10000000,32'h00002008,32'h10000008,32'h10202008,32'h00202000,32'h10200000,
    32'h00202008,32'h10202000,32'h00000000,32'h10200008,32'h00000008,32'h00002000,32'h10200000,32'h00202008,
    32'h00002000,32'h00200008,32'h10002008,32'h00000000,32'h10202000,32'h10000000,32'h00200008,32'h10002008},
  '{32'h00100000,32'h02100001,32'h02000401,32'h00000000,32'h00000400,32'h02000401,32'h00100401,32'h02100400,
    32'h02100401,32'h00100000,32'h00000000,32'h02000001,32'h00000001,32'h02000000,32'h02100001,32'h00000401,
    32'h02000400,32'h00100401,32'h00100001,32'h02000400,32'h02000001,32'h02100000,32'h02100400,32'h00100001,
    32'h02100000,32'h00000400,32'h00000401,32'h02100401,32'h00100400,32'h00000001,32'h02000000,32'h00100400,
    32'h02000000,32'h00100400,32'h00100000,32'h02000401,32'h02000401,32'h02100001,32'h02100001,32'h00000001,
    32'h00100001,32'h02000000,32'h02000400,32'h00100000,32'h02100400,32'h00000401,32'h00100401,32'h02100400,
    32'h00000401,32'h02000001,32'h02100401,32'h02100000,32'h00100400,32'h00000000,32'h00000001,32'h02100401,
    32'h00000000,32'h00100401,32'h02100000,32'h00000400,32'h02000001,32'h02000400,32'h00000400,32'h00100001},
  '{32'h08000820,32'h00000800,32'h00020000,32'h08020820,32'h08000000,32'h08000820,32'h00000020,32'h08000000,
    32'h00020020,32'h08020000,32'h08020820,32'h00020800,32'h08020800,32'h00020820,32'h00000800,32'h00000020,
    32'h08020000,32'h08000020,32'h08000800,32'h00000820,32'h00020800,32'h00020020,32'h08020020,32'h08020800,
    32'h00000820,32'h00000000,32'h00000000,32'h08020020,32'h08000020,32'h08000800,32'h00020820,32'h00020000,
    32'h00020820,32'h00020000,32'h08020800,32'h00000800,32'h00000020,32'h08020020,32'h00000800,32'h00020820,
    32'h08000800,32'h00000020,32'h08000020,32'h08020000,32'h08020020,32'h08000000,32'h00020000,32'h08000820,
    32'h00000000,32'h08020820,32'h00020020,32'h08000020,32'h08020000,32'h08000800,32'h08000820,32'h00000000,
    32'h08020820,32'h00020800,32'h00020800,32'h00000820,32'h00000820,32'h00020020,32'h08000000,32'h08020800}
  };

  // PC-1 on the raw key: C in bits 55..28, D in bits 27..0 (output bit j at 55-j)
  function automatic logic [55:0] pc1(input logic [63:0] key);
    logic [55:0] cd;
    cd = '0;
    for (int j = 0; j < 56; j++) begin
      cd[55-j] = key[6'd63 - (PC1_TAB[j] - 6'd1)];
    end
    return cd;
  endfunction

  // round key for round i: rotate halves by ROT_TAB[i], then PC-2
  function automatic logic [47:0] round_key(input logic [55:0] cd, input logic [3:0] idx);
    logic [55:0] rot;
    logic [47:0] rk;
    logic [4:0]  sh;
    logic [5:0]  src;
    sh = ROT_TAB[idx];
    rot = '0;
    rk = '0;
    for (int j = 0; j < 28; j++) begin
      src = 6'(j) + 6'(sh);
      if (src >= 6'd28) src = src - 6'd28;
      rot[55-j]    = cd[6'd55 - src];
      rot[55-28-j] = cd[6'd27 - src];
    end
    for (int j = 0; j < 48; j++) begin
      rk[47-j] = rot[6'd55 - (PC2_TAB[j] - 6'd1)];
    end
    return rk;
  endfunction

  function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] rk);
    logic [31:0] rt;
    logic [31:0] rl;
    logic [31:0] acc;
    logic [5:0]  ix;
    rt = {r[0], r[31:1]};
    rl = {r[30:0], r[31]};
    acc = '0;
    for (int g = 0; g < 7; g++) begin
      ix = 6'(rt >> (26 - 4*g)) ^ rk[47-6*g -: 6];
      acc = acc | SBOX_P[g][ix];
    end
    ix = rl[5:0] ^ rk[5:0];
    acc = acc | SBOX_P[7][ix];
    return acc;
  endfunction

endpackage

// ===== hw/rtl/dcnp_ctrl.sv =====
module dcnp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_fire,
  output logic               busy_run,
  output logic               out_valid,
  output logic [3:0]         round,
  output dcnp_pkg::cmd_t     cmd
);

  dcnp_pkg::state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      dcnp_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = dcnp_pkg::ST_RUN;
          cnt_nxt = '0;
        end
      end
      dcnp_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = dcnp_pkg::ST_DONE;
      end
      dcnp_pkg::ST_DONE: begin
        if (out_fire) begin
          if (in_fire) begin
            state_nxt = dcnp_pkg::ST_RUN;
            cnt_nxt = '0;
          end else begin
            state_nxt = dcnp_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = dcnp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy_run = (state_r == dcnp_pkg::ST_RUN);
    out_valid = (state_r == dcnp_pkg::ST_DONE);
    cmd.load = in_fire;
    cmd.step = (state_r == dcnp_pkg::ST_RUN);
    cmd.finish = (state_r == dcnp_pkg::ST_RUN) && (cnt_r == 4'd15);
  end

  assign round = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcnp_pkg::ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/dcnp_dp.sv =====
module dcnp_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [63:0]    cfg_wdata,
  input  dcnp_pkg::cmd_t cmd,
  input  logic [3:0]     round,
  input  logic           func,
  input  logic           restart,
  input  logic [63:0]    data_in,
  input  logic           last_in,
  output logic [63:0]    data_out,
  output logic           last_out
);

  logic [55:0] cd_r;
  logic [63:0] chain_r;
  logic [31:0] lh_r, rh_r;
  logic        dec_r;
  logic [63:0] blk_r;
  logic [63:0] res_r;
  logic        last_r;
  logic [63:0] chain_use;
  logic [63:0] pre;
  logic [3:0]  kidx;
  logic [47:0] rk;
  logic [31:0] fo;
  logic [63:0] fin;

  assign chain_use = restart ? 64'd0 : chain_r;
  assign pre = func ? data_in : (data_in ^ chain_use);
  assign kidx = dec_r ? (4'd15 - round) : round;
  assign rk = dcnp_pkg::round_key(cd_r, kidx);
  assign fo = dcnp_pkg::round_f(rh_r, rk);
  // after last round: swap halves
  assign fin = {lh_r ^ fo, rh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= '0;
      chain_r <= '0;
    end else begin
      if (cfg_we) cd_r <= dcnp_pkg::pc1(cfg_wdata);
      if (cmd.load) begin
        if (restart) chain_r <= '0;
      end
      if (cmd.finish) begin
        chain_r <= dec_r ? blk_r : fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lh_r <= pre[63:32];
      rh_r <= pre[31:0];
      dec_r <= func;
      blk_r <= data_in;
      last_r <= last_in;
    end else if (cmd.step) begin
      lh_r <= rh_r;
      rh_r <= lh_r ^ fo;
    end
    if (cmd.finish) begin
      res_r <= dec_r ? (fin ^ chain_r) : fin;
    end
  end

  assign data_out = res_r;
  assign last_out = last_r;

endmodule

// ===== hw/rtl/des_cbc_no_perm_cipher_core.sv =====
// DES in CBC mode, initial and final permutations left out.
// Input stream (in_*): one beat is one 8-byte block. in_tdata holds the block,
// in_tuser selects encrypt (0) or decrypt (1) in bit 0 and restart in bit 1,
// in_tlast is passed to out_tlast untouched.
// Output stream (out_*): one beat per input beat, same order.
// cfg_we/cfg_wdata load the 64-bit key; write only while idle. PC-1 is applied
// at the write and the round key is formed each cycle from the stored halves.
// One Feistel round per cycle in a single shared round unit. A new block is
// not taken while the rounds run; the next block may enter on the cycle its
// predecessor's result is taken.
// A stalled receiver holds the result in its register; a new beat is not
// taken until then, since the chaining value depends on it.
// Reset (synchronous, rst_n low) clears key, chaining value and control.
module des_cbc_no_perm_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] data_in
  input  logic [1:0]  in_tuser,   // [0] func, [1] restart
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] data_out
  output logic        out_tlast
);

  dcnp_pkg::cmd_t cmd;
  logic       busy_run;
  logic [3:0] round;
  logic       in_fire, out_fire;

  assign in_tready = !busy_run && (!out_tvalid || out_tready);
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  dcnp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_fire (out_fire),
    .busy_run (busy_run),
    .out_valid(out_tvalid),
    .round    (round),
    .cmd      (cmd)
  );

  dcnp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .round    (round),
    .func     (in_tuser[0]),
    .restart  (in_tuser[1]),
    .data_in  (in_tdata),
    .last_in  (in_tlast),
    .data_out (out_tdata),
    .last_out (out_tlast)
  );

endmodule
